/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the countdown clock RTL.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define CCL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/ccl_pkg.sv */
// Types and constants for the two-player countdown clock.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccl_pkg;

	localparam int OP_W        = 3;
	localparam int TICK_W      = 17;
	localparam int OUT_TIME_W  = 17;
	localparam int CODE_W      = 3;
	localparam int TDATA_IN_W  = 24;
	localparam int TUSER_IN_W  = 3;
	localparam int TDATA_OUT_W = 40;

	localparam logic [OUT_TIME_W-1:0] INIT_TIME_RESET = OUT_TIME_W'(30 * 60 * 10);

	typedef enum logic [OP_W-1:0] {
		OP_RESET    = 3'd0,
		OP_START    = 3'd1,
		OP_PAUSE    = 3'd2,
		OP_CONTINUE = 3'd3,
		OP_SWITCH   = 3'd4,
		OP_ELAPSE   = 3'd5
	} op_t;

	typedef enum logic [7:0] {
		ST_INITIAL      = 8'b0000_0001,
		ST_STARTABLE    = 8'b0000_0010,
		ST_WHITE_PAUSED = 8'b0000_0100,
		ST_BLACK_PAUSED = 8'b0000_1000,
		ST_WHITE_MOVES  = 8'b0001_0000,
		ST_BLACK_MOVES  = 8'b0010_0000,
		ST_WHITE_WINS   = 8'b0100_0000,
		ST_BLACK_WINS   = 8'b1000_0000
	} mode_t;

	localparam logic [CODE_W-1:0] CODE_INITIAL      = 3'd0;
	localparam logic [CODE_W-1:0] CODE_STARTABLE    = 3'd1;
	localparam logic [CODE_W-1:0] CODE_WHITE_PAUSED = 3'd2;
	localparam logic [CODE_W-1:0] CODE_BLACK_PAUSED = 3'd3;
	localparam logic [CODE_W-1:0] CODE_WHITE_MOVES  = 3'd4;
	localparam logic [CODE_W-1:0] CODE_BLACK_MOVES  = 3'd5;
	localparam logic [CODE_W-1:0] CODE_WHITE_WINS   = 3'd6;
	localparam logic [CODE_W-1:0] CODE_BLACK_WINS   = 3'd7;

	typedef struct packed {
		logic valid;
		logic [OP_W-1:0] opcode;
		logic [TICK_W-1:0] tick_count;
	} cmd_t;

	function automatic logic [CODE_W-1:0] mode_code(mode_t m);
		logic [CODE_W-1:0] c;
		case (m)
			ST_INITIAL:      c = CODE_INITIAL;
			ST_STARTABLE:    c = CODE_STARTABLE;
			ST_WHITE_PAUSED: c = CODE_WHITE_PAUSED;
			ST_BLACK_PAUSED: c = CODE_BLACK_PAUSED;
			ST_WHITE_MOVES:  c = CODE_WHITE_MOVES;
			ST_BLACK_MOVES:  c = CODE_BLACK_MOVES;
			ST_WHITE_WINS:   c = CODE_WHITE_WINS;
			ST_BLACK_WINS:   c = CODE_BLACK_WINS;
			default:         c = CODE_INITIAL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ccl_in_reg.sv */
// Input register of the countdown clock: holds one command item.
// Depends on ccl_pkg.
`default_nettype none

module ccl_in_reg
	import ccl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [TDATA_IN_W-1:0] s_axis_tdata,  // [16:0] tick_count
	input  wire logic [TUSER_IN_W-1:0] s_axis_tuser,  // [2:0] opcode
	input  wire logic                  advance,
	output cmd_t                       cmd_s1
);

	logic              load;
	logic              valid_s1;
	logic [OP_W-1:0]   opcode_s1;
	logic [TICK_W-1:0] tick_s1;

	assign s_axis_tready = !valid_s1 || advance;
	assign load          = s_axis_tvalid && s_axis_tready;
	assign cmd_s1        = {valid_s1, opcode_s1, tick_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			opcode_s1 <= s_axis_tuser[OP_W-1:0];
			tick_s1   <= s_axis_tdata[TICK_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ccl_step.sv */
// Next-state logic of the countdown clock for one command.
// Depends on ccl_pkg.
`default_nettype none

module ccl_step
	import ccl_pkg::*;
#(
	parameter int TIME_WIDTH = 17
) (
	input  mode_t                  mode,
	input  wire logic [TIME_WIDTH-1:0] black_left,
	input  wire logic [TIME_WIDTH-1:0] white_left,
	input  wire logic [OUT_TIME_W-1:0] initial_time,
	input  wire logic [OP_W-1:0]       opcode,
	input  wire logic [TICK_W-1:0]     tick_count,
	output mode_t                      mode_nxt,
	output logic [TIME_WIDTH-1:0]      black_nxt,
	output logic [TIME_WIDTH-1:0]      white_nxt,
	output logic                       ok
);

	localparam int CW = (TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W;

	logic [CW-1:0]         mover_ext;
	logic [CW-1:0]         ticks_ext;
	logic [CW-1:0]         init_ext;
	logic [TIME_WIDTH-1:0] drained;
	logic [TIME_WIDTH-1:0] init_time;

	assign mover_ext = CW'((mode == ST_BLACK_MOVES) ? black_left : white_left);
	assign ticks_ext = CW'(tick_count);
	assign init_ext  = CW'(initial_time);
	assign init_time = init_ext[TIME_WIDTH-1:0];
	assign drained   = (ticks_ext >= mover_ext) ? '0
		: TIME_WIDTH'(mover_ext - ticks_ext);

	always_comb begin
		mode_nxt  = mode;
		black_nxt = black_left;
		white_nxt = white_left;
		ok        = 1'b0;
		case (op_t'(opcode))
			OP_RESET: begin
				if (mode == ST_INITIAL || mode == ST_WHITE_PAUSED ||
					mode == ST_BLACK_PAUSED || mode == ST_WHITE_WINS ||
					mode == ST_BLACK_WINS) begin
					black_nxt = init_time;
					white_nxt = init_time;
					mode_nxt  = ST_STARTABLE;
					ok        = 1'b1;
				end
			end
			OP_START: begin
				if (mode == ST_STARTABLE) begin
					mode_nxt = ST_WHITE_MOVES;
					ok       = 1'b1;
				end
			end
			OP_PAUSE: begin
				if (mode == ST_WHITE_MOVES) begin
					mode_nxt = ST_WHITE_PAUSED;
					ok       = 1'b1;
				end else if (mode == ST_BLACK_MOVES) begin
					mode_nxt = ST_BLACK_PAUSED;
					ok       = 1'b1;
				end
			end
			OP_CONTINUE: begin
				if (mode == ST_WHITE_PAUSED) begin
					mode_nxt = ST_WHITE_MOVES;
					ok       = 1'b1;
				end else if (mode == ST_BLACK_PAUSED) begin
					mode_nxt = ST_BLACK_MOVES;
					ok       = 1'b1;
				end
			end
			OP_SWITCH: begin
				if (mode == ST_WHITE_MOVES) begin
					mode_nxt = ST_BLACK_MOVES;
					ok       = 1'b1;
				end else if (mode == ST_BLACK_MOVES) begin
					mode_nxt = ST_WHITE_MOVES;
					ok       = 1'b1;
				end
			end
			OP_ELAPSE: begin
				if (mode == ST_BLACK_MOVES) begin
					black_nxt = drained;
					ok        = 1'b1;
					if (drained == '0) begin
						mode_nxt = ST_WHITE_WINS;
					end
				end else if (mode == ST_WHITE_MOVES) begin
					white_nxt = drained;
					ok        = 1'b1;
					if (drained == '0) begin
						mode_nxt = ST_BLACK_WINS;
					end
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/two_player_countdown_clock_top.sv */
// Top level of the two-player countdown clock: state and result registers.
// Depends on ccl_pkg, ccl_in_reg, ccl_step and assert_macros.svh.
// Each command item passes an input register and the combinational next-state logic and
// leaves through an output register, so one item is taken per clock while the output
// is not stalled; the output register lets a new item enter while a result waits.
// The state update (one compare and saturating subtract on the clock counter) is
// the only path between the registers. Write initial_time only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module two_player_countdown_clock_top
	import ccl_pkg::*;
#(
	parameter int TIME_WIDTH = 17
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [OUT_TIME_W-1:0]  cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [16:0] tick_count
	input  wire logic [TUSER_IN_W-1:0]  s_axis_tuser,  // [2:0] opcode
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0]      m_axis_tdata   // [16:0] black_time,
	                                                   // [33:17] white_time,
	                                                   // [36:34] game_state,
	                                                   // [37] accepted
);

	localparam int CW = (TIME_WIDTH > OUT_TIME_W) ? TIME_WIDTH : OUT_TIME_W;

	cmd_t                   cmd_s1;
	logic                   advance;
	logic [OUT_TIME_W-1:0]  init_q;
	mode_t                  mode_q;
	logic [TIME_WIDTH-1:0]  black_q;
	logic [TIME_WIDTH-1:0]  white_q;
	mode_t                  mode_nxt;
	logic [TIME_WIDTH-1:0]  black_nxt;
	logic [TIME_WIDTH-1:0]  white_nxt;
	logic                   ok;
	logic [CW-1:0]          black_ext;
	logic [CW-1:0]          white_ext;
	logic                   out_valid_q;
	logic [TDATA_OUT_W-1:0] out_data_q;

	assign advance   = cmd_s1.valid && (!out_valid_q || m_axis_tready);
	assign cfg_ready = 1'b1;

	ccl_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.advance       (advance),
		.cmd_s1        (cmd_s1)
	);

	ccl_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.mode         (mode_q),
		.black_left   (black_q),
		.white_left   (white_q),
		.initial_time (init_q),
		.opcode       (cmd_s1.opcode),
		.tick_count   (cmd_s1.tick_count),
		.mode_nxt     (mode_nxt),
		.black_nxt    (black_nxt),
		.white_nxt    (white_nxt),
		.ok           (ok)
	);

	assign black_ext = CW'(black_nxt);
	assign white_ext = CW'(white_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_TIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			init_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ST_INITIAL;
			black_q <= '0;
			white_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_nxt;
			black_q <= black_nxt;
			white_q <= white_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= cmd_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, ok, mode_code(mode_nxt),
				white_ext[OUT_TIME_W-1:0], black_ext[OUT_TIME_W-1:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`CCL_ASSERT(a_ignored_keeps_state, advance && !ok |=> mode_q == $past(mode_q) && black_q == $past(black_q) && white_q == $past(white_q), "Ignored command changed the clock state.")
	`CCL_ASSERT(a_white_win_black_zero, mode_q == ST_WHITE_WINS |-> black_q == '0, "White wins while black still has time.")
	`CCL_ASSERT(a_black_win_white_zero, mode_q == ST_BLACK_WINS |-> white_q == '0, "Black wins while white still has time.")
	`CCL_NEVER(a_no_take_when_full, cmd_s1.valid && out_valid_q && !m_axis_tready && s_axis_tready, "Input taken while both stages are full.")

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the two-player countdown clock top level.
// Depends on ccl_pkg and two_player_countdown_clock_top; drives command items, checks every
// result against an in-order prediction and sweeps the initial time over several settings.
module testbench;
	import ccl_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic accepted;
		logic [CODE_W-1:0] game_state;
		logic [OUT_TIME_W-1:0] white_time;
		logic [OUT_TIME_W-1:0] black_time;
	} clock_result_t;

	class clock_tracker;
		logic [OUT_TIME_W-1:0] start_tenths;
		logic [CODE_W-1:0] mode;
		logic [OUT_TIME_W-1:0] black_left;
		logic [OUT_TIME_W-1:0] white_left;
		clock_result_t due_results[$];
		int mismatches;
		int checked;
		int ignored;
		int decided;
		int settings;

		function new();
			start_tenths = INIT_TIME_RESET;
			mode = CODE_INITIAL;
			black_left = '0;
			white_left = '0;
			mismatches = 0;
			checked = 0;
			ignored = 0;
			decided = 0;
			settings = 0;
		endfunction

		function void set_initial_time(logic [OUT_TIME_W-1:0] tenths);
			start_tenths = tenths;
			settings++;
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic [TICK_W-1:0] ticks);
			clock_result_t r;
			logic ok;
			ok = 1'b0;
			case (op)
				OP_RESET: begin
					if (mode == CODE_INITIAL || mode == CODE_WHITE_PAUSED ||
					    mode == CODE_BLACK_PAUSED || mode == CODE_WHITE_WINS ||
					    mode == CODE_BLACK_WINS) begin
						black_left = start_tenths;
						white_left = start_tenths;
						mode = CODE_STARTABLE;
						ok = 1'b1;
					end
				end
				OP_START: begin
					if (mode == CODE_STARTABLE) begin
						mode = CODE_WHITE_MOVES;
						ok = 1'b1;
					end
				end
				OP_PAUSE: begin
					if (mode == CODE_WHITE_MOVES) begin
						mode = CODE_WHITE_PAUSED;
						ok = 1'b1;
					end else if (mode == CODE_BLACK_MOVES) begin
						mode = CODE_BLACK_PAUSED;
						ok = 1'b1;
					end
				end
				OP_CONTINUE: begin
					if (mode == CODE_WHITE_PAUSED) begin
						mode = CODE_WHITE_MOVES;
						ok = 1'b1;
					end else if (mode == CODE_BLACK_PAUSED) begin
						mode = CODE_BLACK_MOVES;
						ok = 1'b1;
					end
				end
				OP_SWITCH: begin
					if (mode == CODE_WHITE_MOVES) begin
						mode = CODE_BLACK_MOVES;
						ok = 1'b1;
					end else if (mode == CODE_BLACK_MOVES) begin
						mode = CODE_WHITE_MOVES;
						ok = 1'b1;
					end
				end
				OP_ELAPSE: begin
					if (mode == CODE_BLACK_MOVES) begin
						black_left = (ticks >= black_left) ? '0 : black_left - ticks;
						if (black_left == '0) begin
							mode = CODE_WHITE_WINS;
							decided++;
						end
						ok = 1'b1;
					end else if (mode == CODE_WHITE_MOVES) begin
						white_left = (ticks >= white_left) ? '0 : white_left - ticks;
						if (white_left == '0) begin
							mode = CODE_BLACK_WINS;
							decided++;
						end
						ok = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (!ok)
				ignored++;
			r.accepted = ok;
			r.game_state = mode;
			r.white_time = white_left;
			r.black_time = black_left;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [TDATA_OUT_W-1:0] data);
			clock_result_t got;
			clock_result_t want;
			got = data[$bits(clock_result_t)-1:0];
			checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %h arrived with nothing expected", data);
				return;
			end
			want = due_results.pop_front();
			if (got.black_time !== want.black_time || got.white_time !== want.white_time ||
			    got.game_state !== want.game_state || got.accepted !== want.accepted) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("ERROR: result %0d: expected black %0d white %0d state %0d acc %0b,",
						checked, want.black_time, want.white_time, want.game_state,
						want.accepted);
					$display(" got black %0d white %0d state %0d acc %0b",
						got.black_time, got.white_time, got.game_state, got.accepted);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [OUT_TIME_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [TDATA_IN_W-1:0] s_axis_tdata;
	logic [TUSER_IN_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;

	clock_tracker sb;
	int idle_pct;
	int stall_left;
	int items_sent;
	int quiet_cycles;

	two_player_countdown_clock_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		idle_pct = 0;
		stall_left = 0;
		items_sent = 0;
		quiet_cycles = 0;
	end

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] ticks);
		int gap;
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(0, 99) < 2 * idle_pct) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDATA_IN_W - TICK_W){1'b0}}, ticks};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(op, ticks);
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_initial_time(input logic [OUT_TIME_W-1:0] tenths);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= tenths;
		do @(posedge clk); while (!cfg_ready);
		sb.set_initial_time(tenths);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A game starts the clock and then mostly plays legal moves with random tick counts;
	// a small share of items are arbitrary commands, spare opcodes included.
	task automatic play_game();
		int moves;
		int r;
		logic [CODE_W-1:0] st;
		logic [TICK_W-1:0] ticks;
		send_cmd(OP_RESET, TICK_W'($urandom_range(0, TICK_MAX)));
		send_cmd(OP_START, TICK_W'($urandom_range(0, TICK_MAX)));
		for (moves = 0; moves < 40; moves++) begin
			st = sb.mode;
			if (st == CODE_WHITE_WINS || st == CODE_BLACK_WINS || st == CODE_STARTABLE)
				break;
			r = $urandom_range(0, 99);
			if (r < 10)
				ticks = '0;
			else if (r < 22)
				ticks = TICK_W'($urandom_range(0, TICK_MAX));
			else
				ticks = TICK_W'($urandom_range(0, sb.start_tenths / 5 + 2));
			r = $urandom_range(0, 99);
			if (r < 8)
				send_cmd(OP_W'($urandom_range(0, 7)), TICK_W'($urandom_range(0, TICK_MAX)));
			else if (st == CODE_WHITE_PAUSED || st == CODE_BLACK_PAUSED)
				send_cmd(r < 75 ? OP_CONTINUE : (r < 88 ? OP_RESET : OP_ELAPSE), ticks);
			else if (r < 58)
				send_cmd(OP_ELAPSE, ticks);
			else if (r < 80)
				send_cmd(OP_SWITCH, ticks);
			else if (r < 92)
				send_cmd(OP_PAUSE, ticks);
			else
				send_cmd(r < 96 ? OP_CONTINUE : OP_RESET, ticks);
		end
	endtask

	initial begin
		int p;
		int phase_goal;
		logic [OUT_TIME_W-1:0] setting;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Illegal commands before the first reset, then games at the reset-value time with illegal commands mixed in.
		idle_pct = 5;
		send_cmd(OP_START, '0);
		send_cmd(OP_PAUSE, '0);
		send_cmd(OP_ELAPSE, TICK_MAX);
		send_cmd(OP_SPARE6, '0);
		send_cmd(OP_SPARE7, TICK_MAX);
		send_cmd(OP_RESET, '0);
		send_cmd(OP_RESET, TICK_MAX);
		send_cmd(OP_START, '0);
		send_cmd(OP_RESET, '0);
		send_cmd(OP_ELAPSE, '0);
		send_cmd(OP_ELAPSE, 17'd100);
		send_cmd(OP_SWITCH, '0);
		send_cmd(OP_ELAPSE, TICK_MAX);
		send_cmd(OP_ELAPSE, 17'd5);
		send_cmd(OP_RESET, '0);
		send_cmd(OP_START, '0);
		send_cmd(OP_PAUSE, '0);
		send_cmd(OP_RESET, '0);
		send_cmd(OP_START, '0);
		send_cmd(OP_SWITCH, '0);
		send_cmd(OP_PAUSE, '0);
		send_cmd(OP_CONTINUE, '0);
		send_cmd(OP_CONTINUE, '0);
		send_cmd(OP_SWITCH, '0);
		send_cmd(OP_ELAPSE, 17'd17999);
		send_cmd(OP_ELAPSE, 17'd1);

		for (p = 0; p < 7; p++) begin
			settle();
			case (p)
				0: setting = '0;
				1: setting = '1;
				2: setting = 17'd1;
				3: setting = OUT_TIME_W'($urandom_range(2, 300));
				4: setting = OUT_TIME_W'($urandom_range(0, TICK_MAX));
				5: setting = OUT_TIME_W'($urandom_range(20, 2000));
				default: setting = INIT_TIME_RESET;
			endcase
			write_initial_time(setting);
			idle_pct = (p == 6) ? 0 : 5 * $urandom_range(0, 3);
			if (setting == '0) begin
				// A counter that starts at zero loses on the first elapse, even of no ticks.
				send_cmd(OP_RESET, '0);
				send_cmd(OP_START, '0);
				send_cmd(OP_ELAPSE, '0);
			end
			phase_goal = items_sent + 105;
			while (items_sent < phase_goal)
				play_game();
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Summary: %0d commands, %0d clock settings, %0d ignored, %0d lost on time.",
			items_sent, sb.settings, sb.ignored, sb.decided);
		$display("Summary: %0d results checked, %0d mismatches, %0d still outstanding.",
			sb.checked, sb.mismatches, sb.due_results.size());
		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ccl_pkg.sv
hw/rtl/ccl_in_reg.sv
hw/rtl/ccl_step.sv
hw/rtl/two_player_countdown_clock_top.sv
verif/testbench.sv
